// ===== sv/xmodem_block_receiver_macros.svh =====
// ----------------------------------------------------------------------------
// XMODEM block receiver assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef XMODEM_BLOCK_RECEIVER_MACROS_SVH
`define XMODEM_BLOCK_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define XMBR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xmodem block receiver check failed");

// The consequent must hold in the cycle after the antecedent.
`define XMBR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xmodem block receiver check failed");

`endif

// ===== sv/xmbr_pkg.sv =====
// ----------------------------------------------------------------------------
// XMODEM block receiver package
// Frame constants, operation and status codes, and the item types.
// ----------------------------------------------------------------------------
package xmbr_pkg;

    // Frame layout.
    localparam int PAYLOAD_BYTES = 128;
    localparam int HEADER_LEN    = 3;

    localparam logic [7:0] BYTE_START = 8'h01;
    localparam logic [7:0] BYTE_END   = 8'h04;
    localparam logic [7:0] POS_START  = 8'd0;
    localparam logic [7:0] POS_BLOCK  = 8'd1;
    localparam logic [7:0] POS_COMPL  = 8'd2;
    localparam logic [7:0] POS_DATA   = 8'(HEADER_LEN);
    localparam logic [7:0] POS_CHECK  = 8'(PAYLOAD_BYTES + HEADER_LEN);
    localparam logic [7:0] BLOCK_FIRST = 8'd1;

    // Input operation codes; code 3 is unused.
    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_TIMEOUT = 2'd1,
        OP_RESTART = 2'd2
    } op_t;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_INVALID  = 2'd2,
        ST_RECEIVED = 2'd3
    } status_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        status_t    status;
        logic       payload_valid;
        logic [6:0] payload_index;
        logic [7:0] payload_byte;
    } res_item_t;

endpackage

// ===== sv/xmodem_block_receiver.sv =====
// ----------------------------------------------------------------------------
// XMODEM block receiver
// Checks XMODEM checksum frames byte by byte and reports each data byte with
// its position in the payload, together with a status for every byte.
// ----------------------------------------------------------------------------
//  Channel  | Direction | Handshake          | Item
//  rx       | in        | rx_valid/rx_ready  | rx_item  (op, rx_byte)
//  res      | out       | res_valid/res_ready| res_item (status, payload fields)
//
// One item is taken per cycle while rx_ready is high; each byte's result is
// registered. Frame state updates in the same cycle as acceptance.
// A two-entry output queue (result register plus skid register) lets the
// block take a further item while one result waits; rx_ready falls only when
// both are full. Reset sets the expected block to one and the frame to start.
module xmodem_block_receiver (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rx_valid,
    output logic                rx_ready,
    input  xmbr_pkg::rx_item_t  rx_item,
    output logic                res_valid,
    input  logic                res_ready,
    output xmbr_pkg::res_item_t res_item
);
    import xmbr_pkg::*;

    logic [7:0] block_reg, block_next;
    logic [7:0] pos_reg,   pos_next;
    logic [7:0] sum_reg,   sum_next;

    logic       out_valid_reg;
    res_item_t  out_reg;
    logic       skid_valid_reg;
    res_item_t  skid_reg;

    logic       rx_accept;
    logic       res_pop;
    logic       has_result;
    res_item_t  result;

    assign rx_ready  = !skid_valid_reg;
    assign rx_accept = rx_valid && rx_ready;
    assign res_valid = out_valid_reg;
    assign res_item  = out_reg;
    assign res_pop   = out_valid_reg && res_ready;

    // Frame decoding for the current item.
    always_comb
    begin
        block_next           = block_reg;
        pos_next             = pos_reg;
        sum_next             = sum_reg;
        has_result           = 1'b0;
        result.status        = ST_OK;
        result.payload_valid = 1'b0;
        result.payload_index = 7'd0;
        result.payload_byte  = 8'd0;
        case (rx_item.op)
            OP_TIMEOUT:
            begin
                pos_next = POS_START;
            end
            OP_RESTART:
            begin
                pos_next   = POS_START;
                block_next = BLOCK_FIRST;
            end
            OP_BYTE:
            begin
                has_result = 1'b1;
                if (pos_reg == POS_START)
                begin
                    if (rx_item.rx_byte == BYTE_START)
                    begin
                        pos_next = POS_BLOCK;
                    end
                    else if (rx_item.rx_byte == BYTE_END)
                    begin
                        result.status = ST_COMPLETE;
                    end
                    else
                    begin
                        result.status = ST_INVALID;
                    end
                end
                else if (pos_reg == POS_BLOCK)
                begin
                    if (rx_item.rx_byte == block_reg)
                    begin
                        pos_next = POS_COMPL;
                    end
                    else
                    begin
                        pos_next      = POS_START;
                        result.status = ST_INVALID;
                    end
                end
                else if (pos_reg == POS_COMPL)
                begin
                    if (rx_item.rx_byte == ~block_reg)
                    begin
                        pos_next = POS_DATA;
                        sum_next = 8'd0;
                    end
                    else
                    begin
                        pos_next      = POS_START;
                        result.status = ST_INVALID;
                    end
                end
                else if (pos_reg < POS_CHECK)
                begin
                    sum_next             = sum_reg + rx_item.rx_byte;
                    pos_next             = pos_reg + 8'd1;
                    result.payload_valid = 1'b1;
                    result.payload_index = 7'(pos_reg - POS_DATA);
                    result.payload_byte  = rx_item.rx_byte;
                end
                else
                begin
                    // Checksum byte, or any position past it.
                    pos_next = POS_START;
                    if (rx_item.rx_byte == sum_reg)
                    begin
                        block_next    = block_reg + 8'd1;
                        result.status = ST_RECEIVED;
                    end
                    else
                    begin
                        result.status = ST_INVALID;
                    end
                end
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // Frame state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_reg <= BLOCK_FIRST;
            pos_reg   <= POS_START;
            sum_reg   <= 8'd0;
        end
        else if (rx_accept)
        begin
            block_reg <= block_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // Output queue control: result register at the head, skid register behind.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (res_pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (rx_accept && has_result)
        begin
            if (out_valid_reg && !res_pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (res_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output queue payload.
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (res_pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (rx_accept && has_result)
        begin
            if (out_valid_reg && !res_pop)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

endmodule

// ===== sv/xmbr_checker.sv =====
// ----------------------------------------------------------------------------
// XMODEM block receiver checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "xmodem_block_receiver_macros.svh"

module xmbr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rx_valid,
    input logic                rx_ready,
    input xmbr_pkg::rx_item_t  rx_item,
    input logic                res_valid,
    input logic                res_ready,
    input xmbr_pkg::res_item_t res_item
);
    import xmbr_pkg::*;

    logic res_data;
    logic res_plain;
    logic res_fields_zero;
    logic byte_taken_idle;

    // Short names for the conditions below.
    assign res_data        = res_valid && res_item.payload_valid;
    assign res_plain       = res_valid && !res_item.payload_valid;
    assign res_fields_zero = (res_item.payload_index == 7'd0) &&
                             (res_item.payload_byte == 8'd0);
    assign byte_taken_idle = rx_valid && rx_ready && (rx_item.op == OP_BYTE) && !res_valid;

    // A stalled result holds its value.
    `XMBR_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(res_item))

    // Data bytes are only reported with an ok status.
    `XMBR_ASSERT_NOW(a_payload_ok, res_data, res_item.status == ST_OK)

    // Non-data results carry zero index and byte.
    `XMBR_ASSERT_NOW(a_payload_zero, res_plain, res_fields_zero)

    // A received byte taken while the output is empty shows a result next cycle.
    `XMBR_ASSERT_NEXT(a_byte_result, byte_taken_idle, res_valid)

endmodule

bind xmodem_block_receiver xmbr_checker u_xmbr_checker (.*);
